FILE: design/thm_pkg.sv
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types and constants of the hysteresis thermostat with min/max store.
// ----------------------------------------------------------------------------
package thm_pkg;

  localparam int FIELD_TEMP_W = 16;
  localparam int SIDX_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int BAND_W       = 15;
  localparam int COUNT_W      = 5;
  localparam int TICK_W       = 16;
  localparam int ACT_W        = 7;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_READING = 2'd1,
    OP_REFRESH = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_COOLING = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd6;

  localparam logic signed [FIELD_TEMP_W-1:0] RST_TARGET = 16'sd288;
  localparam logic [BAND_W-1:0]              RST_BAND   = 15'd3;
  localparam logic [TICK_W-1:0]              RST_SETTLE = 16'd100;
  localparam logic [TICK_W-1:0]              RST_PERIOD = 16'd500;
  localparam logic [TICK_W-1:0]              TICK_MAX   = 16'hFFFF;

  typedef struct packed {
    logic signed [FIELD_TEMP_W-1:0] target;
    logic [BAND_W-1:0]              band;
    logic [SIDX_W-1:0]              ctl;
    logic [COUNT_W-1:0]             count;
    logic [TICK_W-1:0]              settle;
    logic [TICK_W-1:0]              period;
    logic                           run_wr;
    logic                           run_val;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic rreq;
  } seq_pulse_t;

endpackage

FILE: design/thm_ifs.sv
// ----------------------------------------------------------------------------
// thm_ifs
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface thm_in_if import thm_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic                           converter_busy;
  logic [SIDX_W-1:0]              sensor_index;
  logic signed [FIELD_TEMP_W-1:0] temperature;
  logic                           last_reading;

  modport source (output valid, operation, converter_busy, sensor_index, temperature,
                  last_reading, input ready);
  modport sink (input valid, operation, converter_busy, sensor_index, temperature,
                last_reading, output ready);
endinterface

interface thm_out_if import thm_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           fan_on;
  logic [1:0]                     control_mode;
  logic                           start_conversion;
  logic                           read_request;
  logic signed [FIELD_TEMP_W-1:0] stored_temperature;
  logic signed [FIELD_TEMP_W-1:0] stored_minimum;
  logic signed [FIELD_TEMP_W-1:0] stored_maximum;

  modport source (output valid, fan_on, control_mode, start_conversion, read_request,
                  stored_temperature, stored_minimum, stored_maximum, input ready);
  modport sink (input valid, fan_on, control_mode, start_conversion, read_request,
                stored_temperature, stored_minimum, stored_maximum, output ready);
endinterface

interface thm_cfg_if import thm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/thm_ram.sv
// ----------------------------------------------------------------------------
// thm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module thm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_b,
  output logic [WIDTH-1:0]                            rdata_a,
  output logic [WIDTH-1:0]                            rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/thm_cfg.sv
// ----------------------------------------------------------------------------
// thm_cfg
// Configuration register file; flags run_enable beats for the mode register.
// ----------------------------------------------------------------------------
module thm_cfg import thm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr,
  input  logic [CFG_IDX_W-1:0]  idx,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_regs_t             regs
);

  logic signed [FIELD_TEMP_W-1:0] target_r;
  logic [BAND_W-1:0]              band_r;
  logic [SIDX_W-1:0]              ctl_r;
  logic [COUNT_W-1:0]             count_r;
  logic [TICK_W-1:0]              settle_r;
  logic [TICK_W-1:0]              period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= RST_TARGET;
      band_r   <= RST_BAND;
      ctl_r    <= '0;
      count_r  <= '0;
      settle_r <= RST_SETTLE;
      period_r <= RST_PERIOD;
    end else if (wr) begin
      case (idx)
        REG_TARGET: target_r <= $signed(data);
        REG_BAND:   band_r   <= data[BAND_W-1:0];
        REG_CTL:    ctl_r    <= data[SIDX_W-1:0];
        REG_COUNT:  count_r  <= data[COUNT_W-1:0];
        REG_SETTLE: settle_r <= data[TICK_W-1:0];
        REG_PERIOD: period_r <= data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    regs.target  = target_r;
    regs.band    = band_r;
    regs.ctl     = ctl_r;
    regs.count   = count_r;
    regs.settle  = settle_r;
    regs.period  = period_r;
    regs.run_wr  = wr && (idx == REG_RUN);
    regs.run_val = data[0];
  end

endmodule

FILE: design/thm_seq.sv
// ----------------------------------------------------------------------------
// thm_seq
// Measurement sequencer: tick counter and conversion/read phase flag.
// ----------------------------------------------------------------------------
module thm_seq import thm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              adv,
  input  logic              busy,
  input  logic              active_nz,
  input  logic [TICK_W-1:0] settle,
  input  logic [TICK_W-1:0] period,
  output seq_pulse_t        pulse
);

  logic [TICK_W-1:0] elapsed_r, elapsed_nxt, inc;
  logic              converting_r, converting_nxt;

  always_comb begin
    inc            = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;
    elapsed_nxt    = inc;
    converting_nxt = converting_r;
    pulse          = '0;
    if (active_nz) begin
      if (converting_r) begin
        if (inc >= settle && !busy) begin
          converting_nxt = 1'b0;
          pulse.rreq     = tick;
        end
      end else if (inc >= period) begin
        pulse.start    = tick;
        elapsed_nxt    = '0;
        converting_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      converting_r <= 1'b1;
    end else if (tick && adv) begin
      elapsed_r    <= elapsed_nxt;
      converting_r <= converting_nxt;
    end
  end

endmodule

FILE: design/hysteresis_thermostat_minmax.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_minmax
// Fan thermostat with hysteresis; per-sensor last/min/max kept in a RAM.
//
//   channel   dir  beat carries
//   in_chan   in   operation, converter_busy, sensor_index, temperature, last
//   out_chan  out  fan_on, control_mode, pulses, stored temp/min/max
//   cfg_chan  in   register index, write data
//
// One item per cycle while results are taken; stage 1 and result are registered.
// Stage 1 reads the sensor RAM (two read ports: addressed and controlled
// sensor); stage 2 updates, decides and writes back, forwarding the last write.
// Reset clears control state and the per-entry valid bits; no clearing pass.
// A stalled result register holds stage 2; input stalls only while stage 2 is held.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_minmax import thm_pkg::*; #(
  parameter int MAX_SENSORS = 16,
  parameter int TEMP_WIDTH  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  thm_in_if.sink   in_chan,
  thm_out_if.source out_chan,
  thm_cfg_if.sink  cfg_chan
);

  localparam int TW    = TEMP_WIDTH;
  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int EW    = 3 * TW;
  localparam int CW    = ((TW > FIELD_TEMP_W) ? TW : FIELD_TEMP_W) + 2;
  localparam logic [ACT_W-1:0] MAX_CNT = ACT_W'(MAX_SENSORS);
  localparam logic [TW-1:0] MIN_RST = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] MAX_RST = {1'b1, {(TW-1){1'b0}}};
  localparam logic [EW-1:0] ENT_RST = {{TW{1'b0}}, MIN_RST, MAX_RST};

  cfg_regs_t  regs;
  seq_pulse_t pulse;

  logic accept, commit;
  logic s1_vld_r;
  op_t  s1_op_r;
  logic s1_busy_r, s1_last_r;
  logic [SIDX_W-1:0]              s1_idx_r;
  logic signed [FIELD_TEMP_W-1:0] s1_temp_r;

  logic [EW-1:0]    rdata_a, rdata_b, ent_a, ent_b, wdata;
  logic [IDX_W-1:0] a_addr, b_addr;
  logic             wb_vld_r;
  logic [IDX_W-1:0] wb_addr_r;
  logic [EW-1:0]    wb_data_r;
  logic             ent_vld_r [MAX_SENSORS];

  logic [ACT_W-1:0]      act;
  logic                  a_in, ctl_in, do_write, decide;
  logic signed [TW-1:0]  temp_in, a_min, a_max, new_min, new_max, t_sel;
  logic signed [CW-1:0]  t_c, tgt_c, lim_c;
  logic [TW-1:0]         q_last, q_min, q_max;
  mode_t                 mode_r, mode_nxt;

  logic        out_vld_r, out_fan_r, out_start_r, out_rreq_r;
  mode_t       out_mode_r;
  logic [FIELD_TEMP_W-1:0] out_st_r, out_min_r, out_max_r;

  thm_cfg u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (cfg_chan.valid && cfg_chan.ready),
    .idx  (cfg_chan.index),
    .data (cfg_chan.data),
    .regs (regs)
  );

  assign cfg_chan.ready = rst_n;

  // pipeline control
  assign commit        = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = rst_n && (!s1_vld_r || commit);
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (commit) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= op_t'(in_chan.operation);
      s1_busy_r <= in_chan.converter_busy;
      s1_idx_r  <= in_chan.sensor_index;
      s1_temp_r <= in_chan.temperature;
      s1_last_r <= in_chan.last_reading;
    end
  end

  thm_ram #(.WIDTH(EW), .DEPTH(MAX_SENSORS)) u_ram (
    .clk    (clk),
    .we     (commit && do_write),
    .waddr  (a_addr),
    .wdata  (wdata),
    .re     (accept),
    .raddr_a(IDX_W'(in_chan.sensor_index)),
    .raddr_b(IDX_W'(regs.ctl)),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  thm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (s1_vld_r && (s1_op_r == OP_TICK)),
    .adv      (commit),
    .busy     (s1_busy_r),
    .active_nz(act != '0),
    .settle   (regs.settle),
    .period   (regs.period),
    .pulse    (pulse)
  );

  generate
    if (TW <= FIELD_TEMP_W) begin : g_tnarrow
      assign temp_in = $signed(s1_temp_r[TW-1:0]);
    end else begin : g_twide
      assign temp_in = TW'(s1_temp_r);
    end
  endgenerate

  // entry lookup: last write forwarded, unwritten entries read as reset value
  assign a_addr = IDX_W'(s1_idx_r);
  assign b_addr = IDX_W'(regs.ctl);
  assign ent_a  = (wb_vld_r && wb_addr_r == a_addr) ? wb_data_r :
                  (ent_vld_r[a_addr] ? rdata_a : ENT_RST);
  assign ent_b  = (wb_vld_r && wb_addr_r == b_addr) ? wb_data_r :
                  (ent_vld_r[b_addr] ? rdata_b : ENT_RST);

  always_comb begin
    act      = ({2'b00, regs.count} > MAX_CNT) ? MAX_CNT : {2'b00, regs.count};
    a_in     = {3'b000, s1_idx_r} < act;
    ctl_in   = {3'b000, regs.ctl} < act;
    do_write = (s1_op_r == OP_READING) && a_in;
    a_min    = $signed(ent_a[TW+:TW]);
    a_max    = $signed(ent_a[0+:TW]);
    new_min  = (temp_in < a_min) ? temp_in : a_min;
    new_max  = (temp_in > a_max) ? temp_in : a_max;
    wdata    = {temp_in, new_min, new_max};

    t_sel  = (do_write && s1_idx_r == regs.ctl) ? temp_in : $signed(ent_b[2*TW+:TW]);
    t_c    = CW'(t_sel);
    tgt_c  = CW'(regs.target);
    lim_c  = tgt_c - CW'($signed({1'b0, regs.band}));
    decide = ((s1_op_r == OP_READING) && s1_last_r) || (s1_op_r == OP_REFRESH);

    mode_nxt = mode_r;
    if (decide) begin
      if (mode_r == MODE_STOPPED || !ctl_in) begin
        mode_nxt = MODE_STOPPED;
      end else if (t_c > tgt_c) begin
        mode_nxt = MODE_COOLING;
      end else if (t_c < lim_c) begin
        mode_nxt = MODE_IDLE;
      end
    end

    q_last = '0;
    q_min  = '0;
    q_max  = '0;
    if (s1_op_r == OP_QUERY && a_in) begin
      q_last = ent_a[2*TW+:TW];
      q_min  = ent_a[TW+:TW];
      q_max  = ent_a[0+:TW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STOPPED;
      wb_vld_r <= 1'b0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
    end else begin
      if (regs.run_wr) begin
        mode_r <= regs.run_val ? ((mode_r == MODE_STOPPED) ? MODE_IDLE : mode_r)
                               : MODE_STOPPED;
      end else if (commit) begin
        mode_r <= mode_nxt;
      end
      if (commit && do_write) begin
        wb_vld_r          <= 1'b1;
        ent_vld_r[a_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && do_write) begin
      wb_addr_r <= a_addr;
      wb_data_r <= wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (commit) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_fan_r   <= (mode_nxt == MODE_COOLING);
      out_mode_r  <= mode_nxt;
      out_start_r <= pulse.start;
      out_rreq_r  <= pulse.rreq;
      out_st_r    <= FIELD_TEMP_W'(q_last);
      out_min_r   <= FIELD_TEMP_W'(q_min);
      out_max_r   <= FIELD_TEMP_W'(q_max);
    end
  end

  assign out_chan.valid              = out_vld_r;
  assign out_chan.fan_on             = out_fan_r;
  assign out_chan.control_mode       = out_mode_r;
  assign out_chan.start_conversion   = out_start_r;
  assign out_chan.read_request       = out_rreq_r;
  assign out_chan.stored_temperature = $signed(out_st_r);
  assign out_chan.stored_minimum     = $signed(out_min_r);
  assign out_chan.stored_maximum     = $signed(out_max_r);

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_start_r && out_rreq_r))
    else $error("start and read request in one beat");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_vld_r)
    else $error("committed item produced no result beat");

  a_run_off: assert property (@(posedge clk) disable iff (!rst_n)
    (regs.run_wr && !regs.run_val) |=> (mode_r == MODE_STOPPED))
    else $error("run disable did not stop the controller");

  a_fan_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_fan_r == (out_mode_r == MODE_COOLING)))
    else $error("fan drive disagrees with mode");

endmodule

FILE: verif/tb_hysteresis_thermostat_minmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hysteresis_thermostat_minmax
// Self-checking bench for the fan thermostat with per-sensor min/max store.
// A beat model of the sequencer, the sensor table and the hysteresis decision
// predicts the status of every accepted beat; each result beat is checked
// field by field. Directed tests cover reset state, value extremes, the band
// edges, the sequencer pulses and long settle/period settings. Randomized
// rounds follow, each with its own register settings. Both sides stall at
// random outside the quiet phases.
// ----------------------------------------------------------------------------
module tb_hysteresis_thermostat_minmax;
  import thm_pkg::*;

  localparam int SENSORS = 16;
  localparam int GAP_PCT = 29;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    op_t                            op;
    logic                           busy;
    logic [SIDX_W-1:0]              sidx;
    logic signed [FIELD_TEMP_W-1:0] temp;
    logic                           last;
  } thm_item_t;

  typedef struct packed {
    logic                           fan;
    logic [1:0]                     mode;
    logic                           start;
    logic                           rreq;
    logic signed [FIELD_TEMP_W-1:0] st;
    logic signed [FIELD_TEMP_W-1:0] smin;
    logic signed [FIELD_TEMP_W-1:0] smax;
  } fan_status_t;

  logic clk;
  logic rst_n;
  bit   quiet;
  int   errors;

  fan_status_t fan_status_q[$];

  // thermostat model state
  logic signed [FIELD_TEMP_W-1:0] last_t [SENSORS];
  logic signed [FIELD_TEMP_W-1:0] low_t  [SENSORS];
  logic signed [FIELD_TEMP_W-1:0] high_t [SENSORS];
  mode_t                          fan_mode;
  logic                           converting;
  logic [TICK_W-1:0]              ticks;

  logic signed [FIELD_TEMP_W-1:0] set_point;
  logic [BAND_W-1:0]              band;
  logic [SIDX_W-1:0]              ctl_sensor;
  logic [COUNT_W-1:0]             n_sensors;
  logic                           run_on;
  logic [TICK_W-1:0]              settle_len;
  logic [TICK_W-1:0]              period_len;

  thm_in_if  in_chan ();
  thm_out_if out_chan ();
  thm_cfg_if cfg_chan ();

  hysteresis_thermostat_minmax dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int sensors_present();
    return (n_sensors > SENSORS) ? SENSORS : int'(n_sensors);
  endfunction

  function automatic void run_decision();
    int t;
    if (fan_mode == MODE_STOPPED || int'(ctl_sensor) >= sensors_present()) begin
      fan_mode = MODE_STOPPED;
      return;
    end
    t = int'(last_t[ctl_sensor]);
    if (t > int'(set_point))
      fan_mode = MODE_COOLING;
    else if (t < int'(set_point) - int'(band))
      fan_mode = MODE_IDLE;
  endfunction

  function automatic fan_status_t thermostat_step(thm_item_t it);
    fan_status_t r;
    int n;
    r = '0;
    n = sensors_present();
    case (it.op)
      OP_TICK: begin
        if (ticks != TICK_MAX) ticks = ticks + 16'd1;
        if (n != 0) begin
          if (converting) begin
            if (ticks >= settle_len && !it.busy) begin
              converting = 1'b0;
              r.rreq = 1'b1;
            end
          end else if (ticks >= period_len) begin
            r.start = 1'b1;
            ticks = '0;
            converting = 1'b1;
          end
        end
      end
      OP_READING: begin
        if (int'(it.sidx) < n) begin
          last_t[it.sidx] = it.temp;
          if (it.temp < low_t[it.sidx]) low_t[it.sidx] = it.temp;
          if (it.temp > high_t[it.sidx]) high_t[it.sidx] = it.temp;
        end
        if (it.last) run_decision();
      end
      OP_REFRESH: run_decision();
      default: begin
        if (int'(it.sidx) < n) begin
          r.st = last_t[it.sidx];
          r.smin = low_t[it.sidx];
          r.smax = high_t[it.sidx];
        end
      end
    endcase
    r.fan = (fan_mode == MODE_COOLING);
    r.mode = fan_mode;
    return r;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET: set_point = data;
      REG_BAND:   band = data[BAND_W-1:0];
      REG_CTL:    ctl_sensor = data[SIDX_W-1:0];
      REG_COUNT:  n_sensors = data[COUNT_W-1:0];
      REG_RUN: begin
        run_on = data[0];
        if (run_on) begin
          if (fan_mode == MODE_STOPPED) fan_mode = MODE_IDLE;
        end else begin
          fan_mode = MODE_STOPPED;
        end
      end
      REG_SETTLE: settle_len = data;
      REG_PERIOD: period_len = data;
      default: ;
    endcase
  endfunction

  function automatic thm_item_t make_beat(op_t op, logic busy, logic [SIDX_W-1:0] sidx,
                                          logic signed [FIELD_TEMP_W-1:0] temp,
                                          logic last);
    thm_item_t it;
    it.op = op;
    it.busy = busy;
    it.sidx = sidx;
    it.temp = temp;
    it.last = last;
    return it;
  endfunction

  task automatic send_item(thm_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < GAP_PCT) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= it.op;
    in_chan.converter_busy <= it.busy;
    in_chan.sensor_index   <= it.sidx;
    in_chan.temperature    <= it.temp;
    in_chan.last_reading   <= it.last;
    do @(posedge clk); while (!in_chan.ready);
    fan_status_q.push_back(thermostat_step(it));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    apply_reg_write(idx, data);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_chan.valid <= 1'b0;
    while (fan_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    fan_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (fan_status_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %h",
                 $time, out_chan.control_mode);
        errors++;
      end else begin
        want = fan_status_q.pop_front();
        cmp_field("fan_on", 16'(want.fan), 16'(out_chan.fan_on));
        cmp_field("control_mode", 16'(want.mode), 16'(out_chan.control_mode));
        cmp_field("start_conversion", 16'(want.start), 16'(out_chan.start_conversion));
        cmp_field("read_request", 16'(want.rreq), 16'(out_chan.read_request));
        cmp_field("stored_temperature", want.st, out_chan.stored_temperature);
        cmp_field("stored_minimum", want.smin, out_chan.stored_minimum);
        cmp_field("stored_maximum", want.smax, out_chan.stored_maximum);
      end
    end
  end

  always @(posedge clk) out_chan.ready <= quiet || ($urandom_range(99) >= GAP_PCT);

  task automatic test_reset_state();
    send_item(make_beat(OP_QUERY, 1'b0, 4'd0, 16'sd0, 1'b0));
    send_item(make_beat(OP_READING, 1'b1, 4'd0, 16'sd500, 1'b1));
    send_item(make_beat(OP_REFRESH, 1'b0, 4'd3, 16'sd0, 1'b0));
    send_item(make_beat(OP_TICK, 1'b0, 4'd0, 16'sd0, 1'b0));
  endtask

  task automatic test_value_extremes();
    wait_quiet();
    write_reg(REG_COUNT, 16'd16);
    write_reg(REG_CTL, 16'd15);
    write_reg(REG_TARGET, 16'h8000);
    write_reg(REG_BAND, 16'd0);
    write_reg(REG_RUN, 16'd1);
    send_item(make_beat(OP_READING, 1'b0, 4'd15, 16'sh7FFF, 1'b1));
    send_item(make_beat(OP_READING, 1'b1, 4'd15, 16'sh8000, 1'b1));
    send_item(make_beat(OP_QUERY, 1'b1, 4'd15, 16'sh7FFF, 1'b1));
    send_item(make_beat(OP_READING, 1'b0, 4'd0, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_TARGET, 16'h7FFF);
    write_reg(REG_BAND, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(make_beat(OP_REFRESH, 1'b1, 4'd15, 16'sh8000, 1'b1));
    send_item(make_beat(OP_QUERY, 1'b0, 4'd0, 16'sd0, 1'b0));
  endtask

  task automatic test_band_edges();
    wait_quiet();
    write_reg(REG_COUNT, 16'd4);
    write_reg(REG_CTL, 16'd2);
    write_reg(REG_TARGET, 16'd288);
    write_reg(REG_BAND, 16'd3);
    send_item(make_beat(OP_READING, 1'b0, 4'd2, 16'sd289, 1'b1));
    send_item(make_beat(OP_READING, 1'b0, 4'd2, 16'sd285, 1'b1));
    send_item(make_beat(OP_READING, 1'b0, 4'd2, 16'sd284, 1'b1));
    send_item(make_beat(OP_READING, 1'b0, 4'd2, 16'sd288, 1'b1));
    // out-of-range index: nothing stored, decision still runs
    send_item(make_beat(OP_READING, 1'b0, 4'd9, 16'sd1000, 1'b1));
    send_item(make_beat(OP_QUERY, 1'b0, 4'd9, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_CTL, 16'd5);
    send_item(make_beat(OP_REFRESH, 1'b0, 4'd0, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_CTL, 16'd2);
    send_item(make_beat(OP_REFRESH, 1'b0, 4'd0, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_RUN, 16'd1);
    send_item(make_beat(OP_QUERY, 1'b0, 4'd2, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_RUN, 16'd0);
    send_item(make_beat(OP_REFRESH, 1'b0, 4'd2, 16'sd0, 1'b0));
  endtask

  task automatic test_sequencer();
    wait_quiet();
    write_reg(REG_COUNT, 16'd20);
    write_reg(REG_SETTLE, 16'd2);
    write_reg(REG_PERIOD, 16'd5);
    send_item(make_beat(OP_READING, 1'b0, 4'd15, 16'sd77, 1'b0));
    for (int i = 0; i < 8; i++)
      send_item(make_beat(OP_TICK, logic'(i == 2), 4'd0, 16'sd0, 1'b0));
  endtask

  task automatic test_long_settle();
    wait_quiet();
    write_reg(REG_COUNT, 16'd0);
    quiet = 1'b1;
    for (int i = 0; i < 10; i++)
      send_item(make_beat(OP_TICK, 1'b0, 4'd0, 16'sd0, 1'b0));
    wait_quiet();
    write_reg(REG_COUNT, 16'd1);
    write_reg(REG_SETTLE, 16'hFFFF);
    write_reg(REG_PERIOD, 16'hFFFF);
    for (int i = 0; i < 3; i++)
      send_item(make_beat(OP_TICK, 1'b0, 4'd0, 16'sd0, 1'b0));
    quiet = 1'b0;
  endtask

  task automatic test_random_rounds();
    thm_item_t it;
    logic [CFG_DATA_W-1:0] d;
    int n;
    int r;
    int off;
    for (int ph = 0; ph < 8; ph++) begin
      wait_quiet();
      quiet = (ph == 3);
      d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(200 + $urandom_range(176));
      write_reg(REG_TARGET, d);
      d = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(8));
      write_reg(REG_BAND, d);
      r = $urandom_range(9);
      d = 16'($urandom);
      d[COUNT_W-1:0] = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
                       5'($urandom_range(1, 16));
      write_reg(REG_COUNT, d);
      n = sensors_present();
      d = 16'($urandom);
      d[SIDX_W-1:0] = (n > 0 && $urandom_range(3) != 0) ? 4'($urandom_range(n - 1)) :
                      4'($urandom_range(15));
      write_reg(REG_CTL, d);
      d = 16'($urandom);
      d[0] = ($urandom_range(7) != 0);
      write_reg(REG_RUN, d);
      d = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(10));
      write_reg(REG_SETTLE, d);
      d = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(16));
      write_reg(REG_PERIOD, d);
      for (int k = 0; k < 113; k++) begin
        r = $urandom_range(99);
        it.op = (r < 40) ? OP_TICK : (r < 70) ? OP_READING : (r < 80) ? OP_REFRESH : OP_QUERY;
        it.busy = ($urandom_range(99) < 35);
        it.sidx = (n > 0 && $urandom_range(4) != 0) ? 4'($urandom_range(n - 1)) :
                  4'($urandom_range(15));
        off = int'($urandom_range(16)) - 8;
        it.temp = ($urandom_range(9) < 7) ? 16'(int'(set_point) + off) : 16'($urandom);
        it.last = ($urandom_range(2) == 0);
        send_item(it);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    errors = 0;
    in_chan.valid = 1'b0;
    in_chan.operation = OP_TICK;
    in_chan.converter_busy = 1'b0;
    in_chan.sensor_index = '0;
    in_chan.temperature = '0;
    in_chan.last_reading = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    out_chan.ready = 1'b0;
    for (int i = 0; i < SENSORS; i++) begin
      last_t[i] = '0;
      low_t[i] = 16'sh7FFF;
      high_t[i] = 16'sh8000;
    end
    fan_mode = MODE_STOPPED;
    converting = 1'b1;
    ticks = '0;
    set_point = RST_TARGET;
    band = RST_BAND;
    ctl_sensor = '0;
    n_sensors = '0;
    run_on = 1'b0;
    settle_len = RST_SETTLE;
    period_len = RST_PERIOD;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_value_extremes();
    test_band_edges();
    test_sequencer();
    test_long_settle();
    test_random_rounds();

    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
design/thm_pkg.sv
design/thm_ifs.sv
design/thm_ram.sv
design/thm_cfg.sv
design/thm_seq.sv
design/hysteresis_thermostat_minmax.sv
verif/tb_hysteresis_thermostat_minmax.sv
